[rtl/sral_pkg.sv]
// ============================================================================
// sral_pkg: shared types and constants of the serial ring line assembler
// Word kinds, store depths and the character codes used for line detection.
// ============================================================================
package sral_pkg;

    localparam int RING_DEPTH = 16;
    localparam int LINE_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef enum logic [1:0] {
        KIND_RX    = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

endpackage

[rtl/sral_if.sv]
// ============================================================================
// sral_req_if / sral_rsp_if: valid/ready channels of the line assembler
// One interface for the action words and one for the result words.
// ============================================================================
interface sral_req_if;
    logic            valid;
    logic            ready;
    sral_pkg::kind_t kind;
    logic [7:0]      rx_byte;
    logic [5:0]      read_index;

    modport source (output valid, output kind, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input rx_byte, input read_index,
                    output ready);
endinterface

interface sral_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       line_ready;
    logic [5:0] line_fill;
    logic       ring_empty;

    modport source (output valid, output read_byte, output line_ready,
                    output line_fill, output ring_empty, input ready);
    modport sink   (input valid, input read_byte, input line_ready,
                    input line_fill, input ring_empty, output ready);
endinterface

[rtl/serial_ring_crlf_line_assembler.sv]
// ============================================================================
// serial_ring_crlf_line_assembler: byte ring feeding a CR LF line store
// Received bytes go into a ring; each tick moves one byte, if the ring holds one and no
// line is held, into the line store and flags a line once it ends in CR LF. Clear and read
// actions work on the line store.
// ============================================================================
//
//  channel | dir | words                                     | handshake
//  --------+-----+-------------------------------------------+------------
//  req     | in  | kind, rx_byte, read_index                 | valid/ready
//  rsp     | out | read_byte, line_ready, line_fill, ring_empty | valid/ready
//
// One word is accepted per cycle while the result register is free or being taken, and its
// result appears in the result register on the next cycle.
// The line store read goes through the RAM's registered read port, which
// lines up with the result register.
// A stalled result blocks new words only while the result register is full
// and not being taken.
// Reset clears pointers, flags and the line store valid bits at once.
module serial_ring_crlf_line_assembler (
    input logic       clk,
    input logic       rst_n,
    sral_req_if.sink   req,
    sral_rsp_if.source rsp
);

    // Ring store (flops, no reset: entries are undefined until written)
    logic [7:0]                   ring_mem [sral_pkg::RING_DEPTH];
    logic [sral_pkg::RING_AW-1:0] ring_wr_ptr_reg, ring_wr_ptr_next;
    logic [sral_pkg::RING_AW-1:0] ring_rd_ptr_reg, ring_rd_ptr_next;

    // Line store control; the two bytes before the fill position are mirrored
    logic [sral_pkg::LINE_AW-1:0]    line_pos_reg, line_pos_next;
    logic                            line_held_reg, line_held_next;
    logic [7:0]                      back1_reg, back1_next;
    logic [7:0]                      back2_reg, back2_next;
    logic [sral_pkg::LINE_DEPTH-1:0] line_vld_reg, line_vld_next;

    // Result register
    logic       out_valid_reg;
    logic       rd_sel_reg, rd_sel_next;
    logic       line_ready_reg;
    logic [5:0] line_fill_reg;
    logic       ring_empty_reg;

    logic                         req_fire;
    logic                         ring_we;
    logic                         move;
    logic                         line_we;
    logic                         line_re;
    logic [sral_pkg::LINE_AW-1:0] line_raddr;
    logic [7:0]                   move_byte;
    logic [7:0]                   line_rdata;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;

    assign move_byte  = ring_mem[ring_rd_ptr_reg];
    assign line_raddr = sral_pkg::LINE_AW'(req.read_index);

    always_comb
    begin
        ring_wr_ptr_next = ring_wr_ptr_reg;
        ring_rd_ptr_next = ring_rd_ptr_reg;
        line_pos_next    = line_pos_reg;
        line_held_next   = line_held_reg;
        back1_next       = back1_reg;
        back2_next       = back2_reg;
        line_vld_next    = line_vld_reg;
        rd_sel_next      = 1'b0;
        ring_we          = 1'b0;
        move             = 1'b0;
        line_we          = 1'b0;
        line_re          = 1'b0;

        if (req_fire)
        begin
            case (req.kind)
                sral_pkg::KIND_RX:
                begin
                    ring_we = 1'b1;
                    if (ring_wr_ptr_reg == sral_pkg::RING_AW'(sral_pkg::RING_DEPTH - 1))
                        ring_wr_ptr_next = '0;
                    else
                        ring_wr_ptr_next = ring_wr_ptr_reg + 1'b1;
                end
                sral_pkg::KIND_TICK:
                begin
                    if (!line_held_reg)
                    begin
                        move = (ring_wr_ptr_reg != ring_rd_ptr_reg);
                        if (move)
                        begin
                            line_we                     = 1'b1;
                            line_vld_next[line_pos_reg] = 1'b1;
                            back1_next                  = move_byte;
                            back2_next                  = back1_reg;
                            if (ring_rd_ptr_reg
                                == sral_pkg::RING_AW'(sral_pkg::RING_DEPTH - 1))
                                ring_rd_ptr_next = '0;
                            else
                                ring_rd_ptr_next = ring_rd_ptr_reg + 1'b1;
                            if (line_pos_reg
                                == sral_pkg::LINE_AW'(sral_pkg::LINE_DEPTH - 1))
                                line_pos_next = '0;
                            else
                                line_pos_next = line_pos_reg + 1'b1;
                        end
                        // The test runs on the fill position after any move.
                        if (back1_next == sral_pkg::CHAR_LF
                            && back2_next == sral_pkg::CHAR_CR)
                        begin
                            line_held_next = 1'b1;
                            line_pos_next  = '0;
                        end
                    end
                end
                sral_pkg::KIND_CLEAR:
                begin
                    line_vld_next  = '0;
                    line_pos_next  = '0;
                    line_held_next = 1'b0;
                    back1_next     = sral_pkg::CHAR_NUL;
                    back2_next     = sral_pkg::CHAR_NUL;
                end
                sral_pkg::KIND_READ:
                begin
                    line_re     = 1'b1;
                    rd_sel_next = (32'(req.read_index) < sral_pkg::LINE_DEPTH)
                                  && line_vld_reg[line_raddr];
                end
                default:
                begin
                    rd_sel_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_wr_ptr_reg <= '0;
            ring_rd_ptr_reg <= '0;
            line_pos_reg    <= '0;
            line_held_reg   <= 1'b0;
            back1_reg       <= sral_pkg::CHAR_NUL;
            back2_reg       <= sral_pkg::CHAR_NUL;
            line_vld_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            ring_wr_ptr_reg <= ring_wr_ptr_next;
            ring_rd_ptr_reg <= ring_rd_ptr_next;
            line_pos_reg    <= line_pos_next;
            line_held_reg   <= line_held_next;
            back1_reg       <= back1_next;
            back2_reg       <= back2_next;
            line_vld_reg    <= line_vld_next;
            if (req_fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wr_ptr_reg] <= req.rx_byte;
        end
        if (req_fire)
        begin
            rd_sel_reg     <= rd_sel_next;
            line_ready_reg <= line_held_next;
            line_fill_reg  <= 6'(line_pos_next);
            ring_empty_reg <= (ring_wr_ptr_next == ring_rd_ptr_next);
        end
    end

    sral_ram #(
        .WIDTH (8),
        .DEPTH (sral_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_pos_reg),
        .wdata (move_byte),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_byte  = rd_sel_reg ? line_rdata : sral_pkg::CHAR_NUL;
    assign rsp.line_ready = line_ready_reg;
    assign rsp.line_fill  = line_fill_reg;
    assign rsp.ring_empty = ring_empty_reg;

    // A held line always sits at fill position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_held_reg |-> line_pos_reg == '0)
        else $error("line held with nonzero fill position");

    // Only a clear word releases a held line.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_held_reg && !(req_fire && req.kind == sral_pkg::KIND_CLEAR)
        |=> line_held_reg)
        else $error("held line dropped without a clear");

    // A clear leaves an empty, unflagged line store.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.kind == sral_pkg::KIND_CLEAR
        |=> !line_held_reg && line_pos_reg == '0 && line_vld_reg == '0)
        else $error("clear did not reset the line store");

    // Line bytes move only out of a non-empty ring and never while a line is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_we |-> ring_wr_ptr_reg != ring_rd_ptr_reg && !line_held_reg)
        else $error("line store written from an empty ring or while held");

endmodule

[rtl/sral_ram.sv]
// ============================================================================
// sral_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds its
// value while the read enable is low.
// ============================================================================
module sral_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[test/line_tracker_pkg.sv]
// ============================================================================
// line_tracker_pkg: scoreboard of the serial ring line assembler
// Mirrors the byte ring and the line store, works out the status word that
// each action word should produce, and compares the result words with it.
// ============================================================================
package line_tracker_pkg;

    import sral_pkg::*;

    typedef struct {
        logic [7:0] read_byte;
        logic       line_ready;
        logic [5:0] line_fill;
        logic       ring_empty;
    } line_status_t;

    class line_tracker;
        logic [7:0]         ring_bytes [RING_DEPTH];
        logic [RING_AW-1:0] wr_ptr;
        logic [RING_AW-1:0] rd_ptr;
        logic [7:0]         line_bytes [LINE_DEPTH];
        logic [LINE_AW-1:0] fill;
        bit                 held;

        line_status_t       pending_status [$];
        int                 errors;
        int                 words_seen;
        int                 results_checked;
        int                 lines_done;
        int                 laps;
        int                 kind_count [4];

        function new();
            foreach (ring_bytes[i])
            begin
                ring_bytes[i] = 8'h00;
            end
            foreach (line_bytes[i])
            begin
                line_bytes[i] = CHAR_NUL;
            end
            wr_ptr = '0;
            rd_ptr = '0;
            fill   = '0;
            held   = 1'b0;
        endfunction

        // One process tick: move a byte out of the ring, if it holds one, unless a line is
        // held, then look for CR LF just behind the fill position.
        function void advance_line();
            int back1;
            int back2;
            if (held)
                return;
            if (wr_ptr != rd_ptr)
            begin
                line_bytes[fill] = ring_bytes[rd_ptr];
                rd_ptr = RING_AW'((rd_ptr + 1) % RING_DEPTH);
                fill   = LINE_AW'((fill + 1) % LINE_DEPTH);
            end
            back1 = (int'(fill) + LINE_DEPTH - 1) % LINE_DEPTH;
            back2 = (int'(fill) + LINE_DEPTH - 2) % LINE_DEPTH;
            if (line_bytes[back1] == CHAR_LF && line_bytes[back2] == CHAR_CR)
            begin
                held = 1'b1;
                fill = '0;
                lines_done++;
            end
        endfunction

        function void note_word(kind_t k, logic [7:0] rx, logic [5:0] idx);
            line_status_t st;
            logic [7:0]   rd;
            rd = 8'h00;
            words_seen++;
            kind_count[int'(k)]++;
            case (k)
                KIND_RX:
                begin
                    // The write pointer catching up with the read pointer
                    // makes the ring look empty again; the data is lost.
                    if (((wr_ptr + 1) % RING_DEPTH) == rd_ptr)
                        laps++;
                    ring_bytes[wr_ptr] = rx;
                    wr_ptr = RING_AW'((wr_ptr + 1) % RING_DEPTH);
                end
                KIND_TICK:
                    advance_line();
                KIND_CLEAR:
                begin
                    foreach (line_bytes[i])
                    begin
                        line_bytes[i] = CHAR_NUL;
                    end
                    fill = '0;
                    held = 1'b0;
                end
                default:
                begin
                    if (idx < LINE_DEPTH)
                        rd = line_bytes[idx];
                end
            endcase
            st.read_byte  = rd;
            st.line_ready = held;
            st.line_fill  = 6'(fill);
            st.ring_empty = (wr_ptr == rd_ptr);
            pending_status.push_back(st);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_result(line_status_t got);
            line_status_t want;
            results_checked++;
            if (pending_status.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing outstanding",
                                 results_checked));
                return;
            end
            want = pending_status.pop_front();
            if (got.read_byte !== want.read_byte)
                report($sformatf("result %0d: read_byte %02h, expected %02h",
                                 results_checked, got.read_byte, want.read_byte));
            if (got.line_ready !== want.line_ready)
                report($sformatf("result %0d: line_ready %b, expected %b",
                                 results_checked, got.line_ready, want.line_ready));
            if (got.line_fill !== want.line_fill)
                report($sformatf("result %0d: line_fill %0d, expected %0d",
                                 results_checked, got.line_fill, want.line_fill));
            if (got.ring_empty !== want.ring_empty)
                report($sformatf("result %0d: ring_empty %b, expected %b",
                                 results_checked, got.ring_empty, want.ring_empty));
        endtask

        task drain_check();
            if (pending_status.size() != 0)
                report($sformatf("%0d results never arrived", pending_status.size()));
        endtask
    endclass

endpackage

[test/tb_top.sv]
// ============================================================================
// tb_top: regression bench of the serial ring line assembler
// Drives action words with random gaps, takes result words with random
// stalls, and checks every result against the line tracker scoreboard.
// ============================================================================
module tb_top;

    import sral_pkg::*;
    import line_tracker_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    sral_req_if req_ch ();
    sral_rsp_if rsp_ch ();

    serial_ring_crlf_line_assembler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    line_tracker sb = new();

    bit sender_burst;
    int stall_pct = 25;
    int results_taken;

    always #10 clk = ~clk;

    initial
    begin
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(25, 60);
    endfunction

    // Offers one word and returns once it has been accepted. Fields that the
    // kind does not use carry random values.
    task automatic send_word(kind_t k, logic [7:0] rx, logic [5:0] idx);
        int gap;
        gap = (!sender_burst && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= k;
        req_ch.rx_byte    <= (k == KIND_RX) ? rx : 8'($urandom);
        req_ch.read_index <= (k == KIND_READ) ? idx : 6'($urandom);
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_word(k, rx, idx);
    endtask

    // A line of random bytes closed by CR LF, fed in chunks that the ticks drain, unless a line
    // is held, before the ring can lap, then a few reads and usually a clear.
    task automatic run_line(int len);
        int         chunk;
        int         queued;
        int         top;
        logic [7:0] b;
        if ($urandom_range(0, 9) < 7)
            send_word(KIND_CLEAR, 8'h00, 6'd0);
        chunk  = $urandom_range(1, 12);
        queued = 0;
        for (int i = 0; i < len + 2; i++)
        begin
            if (i < len)
                b = 8'($urandom);
            else
                b = (i == len) ? CHAR_CR : CHAR_LF;
            send_word(KIND_RX, b, 6'd0);
            queued++;
            if (queued >= chunk || i == len + 1)
            begin
                repeat (queued + $urandom_range(0, 1))
                    send_word(KIND_TICK, 8'h00, 6'd0);
                queued = 0;
                chunk  = $urandom_range(1, 12);
            end
        end
        top = (len + 1 > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : len + 1;
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 3) == 0)
                send_word(KIND_READ, 8'h00, 6'($urandom));
            else
                send_word(KIND_READ, 8'h00, 6'($urandom_range(0, top)));
        end
        if ($urandom_range(0, 4) != 0)
            send_word(KIND_CLEAR, 8'h00, 6'd0);
    endtask

    // Result side: random stalls of changing density, plus one long hold-off
    // that lets the block back up into its input.
    always
    begin
        line_status_t got;
        int           cycle_cnt;
        int           stall_left;
        int           hold_left;
        bit           hold_done;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.read_byte  = rsp_ch.read_byte;
                got.line_ready = rsp_ch.line_ready;
                got.line_fill  = rsp_ch.line_fill;
                got.ring_empty = rsp_ch.ring_empty;
                sb.check_result(got);
                results_taken++;
            end
            @(negedge clk);
            cycle_cnt++;
            if (cycle_cnt % 128 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    2: stall_pct = 25;
                    default: stall_pct = 50;
                endcase
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && results_taken >= 400)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left = 200;
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int         pick;
        int         n;
        int         wait_cycles;
        int         directed_words;
        bit         paused;
        logic [7:0] b;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_RX;
        req_ch.rx_byte    = 8'h00;
        req_ch.read_index = 6'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: reads of the cleared store, a tick on an empty
        // ring, a short CR LF line, a tick while the line is held, clears.
        sender_burst = 1'b0;
        send_word(KIND_READ, 8'h00, 6'd0);
        send_word(KIND_READ, 8'h00, 6'd63);
        send_word(KIND_TICK, 8'h00, 6'd0);
        send_word(KIND_RX, 8'h00, 6'd0);
        send_word(KIND_RX, 8'hFF, 6'd0);
        send_word(KIND_TICK, 8'h00, 6'd0);
        send_word(KIND_TICK, 8'h00, 6'd0);
        send_word(KIND_READ, 8'h00, 6'd1);
        send_word(KIND_RX, CHAR_CR, 6'd0);
        send_word(KIND_RX, CHAR_LF, 6'd0);
        send_word(KIND_TICK, 8'h00, 6'd0);
        send_word(KIND_TICK, 8'h00, 6'd0);
        send_word(KIND_READ, 8'h00, 6'd2);
        send_word(KIND_READ, 8'h00, 6'd3);
        send_word(KIND_RX, 8'h55, 6'd0);
        send_word(KIND_TICK, 8'h00, 6'd0);
        send_word(KIND_READ, 8'h00, 6'd63);
        send_word(KIND_CLEAR, 8'h00, 6'd0);
        send_word(KIND_TICK, 8'h00, 6'd0);
        send_word(KIND_READ, 8'h00, 6'd0);
        send_word(KIND_CLEAR, 8'h00, 6'd0);
        send_word(KIND_RX, 8'hAA, 6'd0);
        send_word(KIND_TICK, 8'h00, 6'd0);
        send_word(KIND_CLEAR, 8'h00, 6'd0);
        directed_words = sb.words_seen;

        paused = 1'b0;
        while (sb.words_seen - directed_words < 1500)
        begin
            sender_burst = ($urandom_range(0, 3) == 0);
            if (!paused && sb.words_seen - directed_words >= 700)
            begin
                // Let the block run completely dry once.
                @(negedge clk);
                req_ch.valid <= 1'b0;
                while (sb.pending_status.size() != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                run_line($urandom_range(0, 20));
            else if (pick < 65)
            begin
                // Sixty-two body bytes put CR LF in the last two entries, so
                // the fill position wraps to zero as the line completes.
                run_line(($urandom_range(0, 2) == 0) ? 62 : $urandom_range(58, 72));
            end
            else if (pick < 75)
            begin
                send_word(KIND_CLEAR, 8'h00, 6'd0);
                n = $urandom_range(14, 24);
                repeat (n)
                    send_word(KIND_RX, 8'($urandom), 6'd0);
                repeat (20)
                    send_word(KIND_TICK, 8'h00, 6'd0);
                repeat (2)
                    send_word(KIND_READ, 8'h00, 6'($urandom_range(0, 19)));
            end
            else if (pick < 90)
            begin
                // Dense mix of CR and LF bytes to hit partial and stray
                // terminators.
                repeat (30)
                begin
                    n = $urandom_range(0, 99);
                    if (n < 50)
                    begin
                        case ($urandom_range(0, 2))
                            0: b = CHAR_CR;
                            1: b = CHAR_LF;
                            default: b = 8'($urandom);
                        endcase
                        send_word(KIND_RX, b, 6'd0);
                    end
                    else if (n < 85)
                        send_word(KIND_TICK, 8'h00, 6'd0);
                    else if (n < 95)
                        send_word(KIND_READ, 8'h00, 6'($urandom));
                    else
                        send_word(KIND_CLEAR, 8'h00, 6'd0);
                end
            end
            else
            begin
                repeat (8)
                    send_word(kind_t'($urandom_range(0, 3)), 8'($urandom), 6'($urandom));
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        for (wait_cycles = 0; sb.pending_status.size() != 0 && wait_cycles < 20000;
             wait_cycles++)
            @(posedge clk);
        repeat (16) @(posedge clk);
        sb.drain_check();

        $display("Run covered %0d words: %0d bytes, %0d ticks, %0d clears, %0d reads.",
                 sb.words_seen, sb.kind_count[KIND_RX], sb.kind_count[KIND_TICK],
                 sb.kind_count[KIND_CLEAR], sb.kind_count[KIND_READ]);
        $display("It completed %0d CR LF lines and lapped the ring %0d times.",
                 sb.lines_done, sb.laps);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
